// ===== src/ese_pkg.sv =====
// ----------------------------------------------------------------------------
// ese_pkg: shared types and constants of the encoder speed estimator
// Field widths, register map, control struct from the register block to the
// core, and the operand widths of the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package ese_pkg;

   // Field widths
   localparam int COUNT_W = 16;
   localparam int DIFF_W  = 17;
   localparam int SCALE_W = 24;
   localparam int GAIN_W  = 17;
   localparam int POS_W   = 32;
   localparam int SPEED_W = 40;
   localparam int DELTA_W = 41;

   // Shared multiplier: signed A times signed B, product registered
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Partial products of the filter update
   localparam int HI_W   = 34;
   localparam int STEP_W = 42;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_COUNT_INVERT = 2'd0;
   localparam logic [1:0] REG_SPEED_SCALE  = 2'd1;
   localparam logic [1:0] REG_FILTER_GAIN  = 2'd2;

   // Reset values and unity gain
   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
   localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;

   // Settings and write strobe from the register block
   typedef struct packed {
      logic               count_invert;
      logic [SCALE_W-1:0] speed_scale;
      logic [GAIN_W-1:0]  filter_gain;
      logic               gain_wr;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/ese_req_if.sv =====
// ----------------------------------------------------------------------------
// ese_req_if: encoder sample channel
// Valid/ready channel carrying one sampled encoder count per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ese_req_if;
   import ese_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] encoder_count;

   modport source (output valid, output encoder_count, input ready);
   modport sink   (input valid, input encoder_count, output ready);
endinterface

`default_nettype wire

// ===== src/ese_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ese_rsp_if: speed result channel
// Valid/ready channel carrying position, raw and filtered speed per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ese_rsp_if;
   import ese_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [POS_W-1:0]   position;
   logic signed [SPEED_W-1:0] raw_speed;
   logic signed [SPEED_W-1:0] filtered_speed;
   logic                      speed_valid;

   modport source (output valid, output position, output raw_speed,
                   output filtered_speed, output speed_valid, input ready);
   modport sink   (input valid, input position, input raw_speed,
                   input filtered_speed, input speed_valid, output ready);
endinterface

`default_nettype wire

// ===== src/ese_mul.sv =====
// ----------------------------------------------------------------------------
// ese_mul: shared signed multiplier
// 18 x 25 bit signed multiply with the product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_mul (
   input  wire logic                               clock,
   input  wire logic signed [ese_pkg::MUL_A_W-1:0] mul_a,
   input  wire logic signed [ese_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [ese_pkg::MUL_P_W-1:0]      prod_ff
);
   import ese_pkg::*;

   logic signed [MUL_P_W-1:0] prod_in;

   // Form the product
   always_comb begin
      prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   // Register it
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== src/ese_csr.sv =====
// ----------------------------------------------------------------------------
// ese_csr: configuration registers
// APB-style write/read of count_invert, speed_scale and filter_gain; flags
// a gain write so the core can reseed its filter.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [ese_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [ese_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic      [ese_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                      pready,
   output ese_pkg::cfg_type                          cfg
);
   import ese_pkg::*;

   logic               invert_ff, invert_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // Decode writes
   always_comb begin
      invert_in = invert_ff;
      scale_in  = scale_ff;
      gain_in   = gain_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_COUNT_INVERT: invert_in = pwdata[0];
            REG_SPEED_SCALE:  scale_in  = pwdata[SCALE_W-1:0];
            REG_FILTER_GAIN:  gain_in   = pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
         scale_ff  <= SCALE_RESET;
         gain_ff   <= GAIN_ONE;
      end else begin
         invert_ff <= invert_in;
         scale_ff  <= scale_in;
         gain_ff   <= gain_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_COUNT_INVERT: prdata = {{(CSR_DATA_W-1){1'b0}}, invert_ff};
         REG_SPEED_SCALE:  prdata = {{(CSR_DATA_W-SCALE_W){1'b0}}, scale_ff};
         REG_FILTER_GAIN:  prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, gain_ff};
         default:          prdata = '0;
      endcase
   end

   // Settings to the core, gain write strobe at the write edge
   always_comb begin
      cfg.count_invert = invert_ff;
      cfg.speed_scale  = scale_ff;
      cfg.filter_gain  = gain_ff;
      cfg.gain_wr      = wr_en && (reg_idx == REG_FILTER_GAIN);
   end

endmodule

`default_nettype wire

// ===== src/ese_core.sv =====
// ----------------------------------------------------------------------------
// ese_core: sequencer and datapath of the speed estimator
// Takes one count word, forms the difference and position, then runs the
// raw speed and the filter update through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ese_pkg::cfg_type cfg,
   ese_req_if.sink               req,
   ese_rsp_if.source             rsp
);
   import ese_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_RAW   = 8'b00000010,
      S_DELTA = 8'b00000100,
      S_MHI   = 8'b00001000,
      S_MLO   = 8'b00010000,
      S_STEP  = 8'b00100000,
      S_UPD   = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  prev_ff, prev_in;
   logic                awaiting_ff, awaiting_in;
   logic                seeded_ff, seeded_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [SPEED_W-1:0]  raw_ff, raw_in;
   logic [SPEED_W-1:0]  smooth_ff, smooth_in;
   logic [DIFF_W-1:0]   diff_ff, diff_in;
   logic [DELTA_W-1:0]  delta_ff, delta_in;
   logic [HI_W-1:0]     hi_ff, hi_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                flag_ff, flag_in;
   logic                out_valid_ff, out_valid_in;
   logic [POS_W-1:0]    out_pos_ff, out_pos_in;
   logic [SPEED_W-1:0]  out_raw_ff, out_raw_in;
   logic [SPEED_W-1:0]  out_filt_ff, out_filt_in;
   logic                out_sv_ff, out_sv_in;

   logic                      req_fire;
   logic                      out_free;
   logic [COUNT_W-1:0]        d16;
   logic [DIFF_W-1:0]         diff_raw;
   logic [GAIN_W-1:0]         gain_sat;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0]        prod_u;

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !out_valid_ff || rsp.ready;
   assign prod_u    = MUL_P_W'(prod_ff);

   // Wrap-around count difference, negated on request
   assign d16      = req.encoder_count - prev_ff;
   assign diff_raw = cfg.count_invert ? (DIFF_W'(0) - {d16[COUNT_W-1], d16})
                                      : {d16[COUNT_W-1], d16};

   // Clamp gain to unity
   assign gain_sat = (cfg.filter_gain > GAIN_ONE) ? GAIN_ONE : cfg.filter_gain;

   // Select multiplier operands by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_RAW: begin
            mul_a = {diff_ff[DIFF_W-1], diff_ff};
            mul_b = {1'b0, cfg.speed_scale};
         end
         S_MHI: begin
            mul_a = {delta_ff[DELTA_W-1], delta_ff[DELTA_W-1:24]};
            mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, gain_sat};
         end
         S_MLO: begin
            mul_a = {1'b0, gain_sat};
            mul_b = {1'b0, delta_ff[23:0]};
         end
         default: ;
      endcase
   end

   ese_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      awaiting_in  = awaiting_ff;
      seeded_in    = seeded_ff;
      pos_in       = pos_ff;
      raw_in       = raw_ff;
      smooth_in    = smooth_ff;
      diff_in      = diff_ff;
      delta_in     = delta_ff;
      hi_in        = hi_ff;
      step_in      = step_ff;
      flag_in      = flag_ff;
      out_valid_in = out_valid_ff;
      out_pos_in   = out_pos_ff;
      out_raw_in   = out_raw_ff;
      out_filt_in  = out_filt_ff;
      out_sv_in    = out_sv_ff;

      // Drop the output word once taken
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               prev_in = req.encoder_count;
               diff_in = diff_raw;
               if (awaiting_ff) begin
                  awaiting_in = 1'b0;
                  flag_in     = 1'b0;
                  state_in    = S_DONE;
               end else begin
                  flag_in  = 1'b1;
                  state_in = S_RAW;
               end
            end
         end
         S_RAW: begin
            pos_in   = pos_ff + {{(POS_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
            state_in = S_DELTA;
         end
         S_DELTA: begin
            raw_in   = prod_u[SPEED_W-1:0];
            delta_in = {prod_u[SPEED_W-1], prod_u[SPEED_W-1:0]}
                     - {smooth_ff[SPEED_W-1], smooth_ff};
            if (!seeded_ff) begin
               smooth_in = prod_u[SPEED_W-1:0];
               seeded_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               state_in = S_MHI;
            end
         end
         S_MHI: begin
            state_in = S_MLO;
         end
         S_MLO: begin
            // Hold the high partial product
            hi_in    = prod_u[HI_W-1:0];
            state_in = S_STEP;
         end
         S_STEP: begin
            // floor((hi * 2^24 + lo) / 2^16) = hi * 2^8 + (lo >> 16), lo >= 0
            step_in  = {hi_ff, 8'b0}
                     + {{(STEP_W-25){1'b0}}, prod_u[40:16]};
            state_in = S_UPD;
         end
         S_UPD: begin
            smooth_in = smooth_ff + step_ff[SPEED_W-1:0];
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_pos_in   = pos_ff;
               out_raw_in   = flag_ff ? raw_ff : '0;
               out_filt_in  = flag_ff ? smooth_ff : '0;
               out_sv_in    = flag_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Reseed the filter on a gain write
      if (cfg.gain_wr) begin
         smooth_in = raw_ff;
         seeded_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         awaiting_ff  <= 1'b1;
         seeded_ff    <= 1'b0;
         pos_ff       <= '0;
         raw_ff       <= '0;
         smooth_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         awaiting_ff  <= awaiting_in;
         seeded_ff    <= seeded_in;
         pos_ff       <= pos_in;
         raw_ff       <= raw_in;
         smooth_ff    <= smooth_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working and output payload
   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      delta_ff    <= delta_in;
      hi_ff       <= hi_in;
      step_ff     <= step_in;
      flag_ff     <= flag_in;
      out_pos_ff  <= out_pos_in;
      out_raw_ff  <= out_raw_in;
      out_filt_ff <= out_filt_in;
      out_sv_ff   <= out_sv_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.position       = out_pos_ff;
   assign rsp.raw_speed      = out_raw_ff;
   assign rsp.filtered_speed = out_filt_ff;
   assign rsp.speed_valid    = out_sv_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("accepted word did not start the sequence");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("output word loaded outside the done step");

   a_seeded_sticks: assert property (@(posedge clock) disable iff (reset)
      seeded_ff |=> seeded_ff)
      else $error("filter seed flag dropped");

   a_filter_needs_seed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MHI) |-> (seeded_ff && flag_ff))
      else $error("filter update without seeded filter");
`endif

endmodule

`default_nettype wire

// ===== src/encoder_speed_estimator.sv =====
// ----------------------------------------------------------------------------
// encoder_speed_estimator: position and speed from a sampled encoder counter
// Each count word yields position, raw speed (Q24.16) and low-pass filtered
// speed; the first word after reset only seeds the last count. Timing: the
// block is busy from acceptance until its result word is loaded into the
// output register. A seeding word goes straight to the load step, the first
// speed word runs the raw speed multiply first, and every later word also runs
// the filter steps; the one shared 18 x 25 multiplier computes the raw speed
// and then the two partial products of the filter gain times the 41-bit speed
// error. A result waiting in the output register does not block acceptance of
// the next word; it holds only the final load step. Registers: count_invert at
// 0x0, speed_scale at 0x4, filter_gain at 0x8; writing filter_gain reseeds the
// filter from the last raw speed. Write registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_estimator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ese_req_if.sink                             req_chan,
   ese_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ese_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ese_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ese_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ese_pkg::*;

   cfg_type cfg;

   // Register block
   ese_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Sequencer, datapath and output register
   ese_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire
